// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files of the decimal text unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
  `ASSERT_CLK(name, clk, rst, !(cond), msg)

`endif

// ===== src/sidau_pkg.sv =====
// Package with the types and constants of the decimal text unit.
package sidau_pkg;

  localparam int MAG_W       = 32;
  localparam int THR_W       = MAG_W + 2;
  localparam int NUM_DIGITS  = 10;
  localparam int POS_W       = 4;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CODE_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CODE_ZERO  = 8'd48;

  localparam logic [MAG_W-1:0] POW10 [NUM_DIGITS] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [POS_W-1:0] top;
  } item_t;

endpackage

// ===== src/sidau_front.sv =====
// Front end: splits sign from magnitude and counts the decimal digits.
`include "assert_macros.svh"

module sidau_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         value,
  output logic                       push,
  output sidau_pkg::item_t           push_data,
  input  logic                       full
);
  import sidau_pkg::*;

  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [POS_W-1:0] top;

  always_comb begin
    neg = value[MAG_W-1];
    mag = neg ? (MAG_W'(0) - MAG_W'(value)) : MAG_W'(value);
    top = '0;
    for (int k = 1; k < NUM_DIGITS; k++) begin
      if (mag >= POW10[k]) begin
        top = top + POS_W'(1);
      end
    end
  end

  assign in_stall  = full;
  assign push      = in_valid && !full;
  assign push_data = '{neg: neg, mag: mag, top: top};

  `ASSERT_CLK(a_top_fits, clk, rst, !push || (push_data.top < POS_W'(NUM_DIGITS)),
              "digit count out of range")

endmodule

// ===== src/sidau_queue.sv =====
// Short queue between the front end and the character generator.
`include "assert_macros.svh"

module sidau_queue #(
  parameter int DEPTH = sidau_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sidau_pkg::item_t push_data,
  output logic             full,
  input  logic             pop,
  output sidau_pkg::item_t pop_data,
  output logic             nonempty
);
  import sidau_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && full && !pop, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && !nonempty, "pop from empty queue")

endmodule

// ===== src/sidau_back.sv =====
// Back end: emits the sign and the digits, one character per transaction.
`include "assert_macros.svh"

module sidau_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                nonempty,
  input  sidau_pkg::item_t                    pop_data,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sidau_pkg::CHAR_W-1:0]        char_code,
  output logic                                last
);
  import sidau_pkg::*;

  logic               busy;
  logic               neg_pend;
  logic [MAG_W-1:0]   mag;
  logic [POS_W-1:0]   pos;
  logic               adv;
  logic [THR_W-1:0]   thr [NUM_DIGITS];
  logic [DIGIT_W-1:0] digit;
  logic [MAG_W-1:0]   rem;

  always_comb begin
    thr[0] = '0;
    digit  = '0;
    for (int k = 1; k < NUM_DIGITS; k++) begin
      thr[k] = THR_W'(k) * {2'b00, POW10[pos]};
      if ({2'b00, mag} >= thr[k]) begin
        digit = digit + DIGIT_W'(1);
      end
    end
    rem = mag - thr[digit][MAG_W-1:0];
  end

  assign adv = !out_valid || !out_stall;
  assign pop = !busy && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      neg_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy     <= 1'b1;
        neg_pend <= pop_data.neg;
      end else if (busy && adv) begin
        if (neg_pend) begin
          neg_pend <= 1'b0;
        end else if (pos == '0) begin
          busy <= 1'b0;
        end
      end
      if (adv) begin
        out_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mag <= pop_data.mag;
      pos <= pop_data.top;
    end else if (busy && adv) begin
      if (neg_pend) begin
        char_code <= CODE_MINUS;
        last      <= 1'b0;
      end else begin
        char_code <= CODE_ZERO + CHAR_W'(digit);
        last      <= (pos == '0);
        mag       <= rem;
        pos       <= pos - POS_W'(1);
      end
    end
  end

  `ASSERT_NEVER(a_final_digit, clk, rst, busy && !neg_pend && pos == '0 && mag >= MAG_W'(10),
                "remainder too large at final digit")
  `ASSERT_CLK(a_load_busy, clk, rst, pop |=> busy, "load did not start conversion")
  `ASSERT_CLK(a_valid_source, clk, rst, $rose(out_valid) |-> $past(busy),
              "character without conversion")

endmodule

// ===== src/signed_int_to_decimal_ascii_unit.sv =====
// Top level of the signed integer to decimal text unit.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------
//   in      | in_valid / in_stall  | value (32b signed)
//   out     | out_valid / out_stall| char_code (8b), last
//
// A value of n characters (sign plus digits, 1 to 11) is first loaded from
// the queue, then the digit unit emits its characters one at a time.
// Digit extraction compares the remainder against the nine multiples of the
// current power of ten, one digit per unstalled cycle, most significant first.
// The two-entry queue lets the input accept while characters are still leaving.
// rst is synchronous and clears the queue, the digit unit and the output valid.
// A stalled output holds its character; the digit unit waits with it.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_unit #(
  parameter int QUEUE_DEPTH = sidau_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sidau_pkg::CHAR_W-1:0] char_code,
  output logic                         last
);
  import sidau_pkg::*;

  logic  push;
  item_t push_data;
  logic  full;
  logic  pop;
  item_t pop_data;
  logic  nonempty;

  sidau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  sidau_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .nonempty  (nonempty)
  );

  sidau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

endmodule

// ===== test/tb_signed_int_to_decimal_ascii_unit.sv =====
// Testbench for the signed integer to decimal ASCII unit, with a scoreboard.
module tb_signed_int_to_decimal_ascii_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sidau_pkg::*;

  localparam int NUM_RANDOM  = 420;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_TICKS = 16;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  class decimal_text_scoreboard;
    ascii_char_t expected_chars[$];
    int errors;
    int values_seen;
    int negatives_seen;
    int chars_checked;
    int longest_text;

    function new();
      errors = 0;
      values_seen = 0;
      negatives_seen = 0;
      chars_checked = 0;
      longest_text = 0;
    endfunction

    function void note_value(logic [31:0] v);
      logic [31:0] mag;
      logic [3:0]  digit_buf [NUM_DIGITS];
      int          nd;
      int          len;
      ascii_char_t c;
      nd = 0;
      mag = v[31] ? (32'd0 - v) : v;
      do begin
        digit_buf[nd] = 4'(mag % 32'd10);
        nd++;
        mag = mag / 32'd10;
      end while (mag != 0 && nd < NUM_DIGITS);
      len = nd;
      if (v[31]) begin
        c.code = CODE_MINUS;
        c.last = 1'b0;
        expected_chars.push_back(c);
        negatives_seen++;
        len++;
      end
      for (int k = nd - 1; k >= 0; k--) begin
        c.code = CODE_ZERO + CHAR_W'(digit_buf[k]);
        c.last = (k == 0);
        expected_chars.push_back(c);
      end
      values_seen++;
      if (len > longest_text) longest_text = len;
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic last);
      ascii_char_t exp_c;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: char_code %0d last %0b", code, last);
        errors++;
        return;
      end
      exp_c = expected_chars.pop_front();
      chars_checked++;
      if (code !== exp_c.code) begin
        $error("char_code: expected %0d, actual %0d", exp_c.code, code);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("last: expected %0b, actual %0b", exp_c.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic signed [31:0] value;
  logic              out_valid;
  logic              out_stall;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  decimal_text_scoreboard sb;
  bit steady_flow;
  int idle_cycles;

  signed_int_to_decimal_ascii_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned kind;
    int unsigned ndig;
    bit          neg;
    longint      p;
    longint      lo;
    longint      hi;
    longint      mag;
    kind = $urandom_range(0, 9);
    if (kind < 2) return $urandom;
    ndig = $urandom_range(1, NUM_DIGITS);
    neg = $urandom_range(0, 1);
    p = 1;
    repeat (ndig - 1) p = p * 10;
    lo = (ndig == 1) ? 0 : p;
    hi = p * 10 - 1;
    if (hi > 64'sd2147483647) hi = neg ? 64'sd2147483648 : 64'sd2147483647;
    mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  task automatic send_value(input logic [31:0] v, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      value = $urandom;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    value = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stall the output side
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_value(value);
      if (out_valid && !out_stall) sb.check_char(char_code, last);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout with %0d characters outstanding", sb.expected_chars.size());
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [31:0] directed [] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'd2147483647, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
      32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd123456789,
      -32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd7, 32'd7,
      32'd1000000001, -32'sd100, 32'd2000000000
    };
    sb = new();
    steady_flow = 1'b0;
    idle_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_value(directed[i], pick_gap());
    for (int i = 0; i < NUM_RANDOM; i++) begin
      steady_flow = (i >= 150 && i < 230);
      send_value(pick_value(), pick_gap());
    end
    steady_flow = 1'b0;
    in_valid = 1'b0;

    // drain
    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);

    $display("converted %0d values (%0d negative) into %0d characters",
             sb.values_seen, sb.negatives_seen, sb.chars_checked);
    $display("longest text %0d characters, %0d mismatches", sb.longest_text, sb.errors);
    if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== signed_int_to_decimal_ascii_unit.f =====
+incdir+src
src/sidau_pkg.sv
src/sidau_front.sv
src/sidau_queue.sv
src/sidau_back.sv
src/signed_int_to_decimal_ascii_unit.sv
test/tb_signed_int_to_decimal_ascii_unit.sv
